/* src/cst_pkg.sv */
// Shared types, codes and character classes for the C source tokenizer.
`default_nettype none

package cst_pkg;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_HASH,
        MODE_OPS,
        MODE_STR,
        MODE_STR_ESC,
        MODE_STR_DONE,
        MODE_DONE,
        MODE_SLASH,
        MODE_COMMENT,
        MODE_COMMENT_STAR
    } mode_t;

    typedef enum logic [2:0] {
        CTL_RUN,
        CTL_LABEL,
        CTL_EMIT,
        CTL_ERROR,
        CTL_HALT
    } ctl_t;

    typedef logic [1:0] err_t;

    localparam err_t ERR_NONE     = 2'd0;
    localparam err_t ERR_TOO_LONG = 2'd1;
    localparam err_t ERR_OPEN_STR = 2'd2;
    localparam err_t ERR_OPEN_CMT = 2'd3;

    localparam int LINE_W = 24;
    localparam logic [LINE_W-1:0] LINE_MAX = 24'hFFFFFF;

    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SQUOTE  = 8'h27;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;

    function automatic logic is_ident(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
               (b >= 8'h30 && b <= 8'h39) || (b == 8'h5F);
    endfunction

    function automatic logic is_op(input logic [7:0] b);
        return (b == 8'h3C) || (b == 8'h3D) || (b == 8'h3E) || (b == 8'h7C) ||
               (b == 8'h26) || (b == 8'h21) || (b == 8'h2D);
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_TAB);
    endfunction

    function automatic mode_t start_mode(input logic [7:0] b);
        mode_t m;
        if (b == CH_HASH)
            m = MODE_HASH;
        else if (is_ident(b))
            m = MODE_IDENT;
        else if (is_op(b))
            m = MODE_OPS;
        else if (b == CH_SQUOTE || b == CH_DQUOTE)
            m = MODE_STR;
        else if (b == CH_SLASH)
            m = MODE_SLASH;
        else
            m = MODE_DONE;
        return m;
    endfunction

endpackage

`default_nettype wire

/* src/c_source_tokenizer.sv */
// Top level of the C source tokenizer: lexer control, token memory and result register.
//
// Source bytes enter on the s_ channel, one request per byte; s_tlast marks end of source
// and its byte is ignored. Tokens leave on the m_ channel one character per request,
// m_tlast on the final character, with the line count and an error code.
// A byte that only extends a token is written to the token memory. A byte that closes a
// token starts a registered readout of the token memory at one character per cycle while
// the receiver does not stall; a label first sends its ':'.
// The token memory has one write and one read port; the first character of the next
// token is written while character zero of the old one is read.
// An over-long token, an open string or an open comment at end of source gives a single
// result with a nonzero error code; the block then takes and drops every byte until reset.
// Reset clears the lexer to idle with the line count at one; memory contents are not
// cleared and need no clearing pass. When the receiver stalls, the result register holds
// and the readout pauses; bytes are taken only when the read register is empty.
`default_nettype none

module c_source_tokenizer #(
    parameter int MAX_TOKEN_LEN = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] byte_in
    input  wire logic        s_tlast,   // end_of_input
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] token_char, [31:8] line_number
    output logic             m_tlast,   // token_last
    output cst_pkg::err_t    m_tuser    // [1:0] error_code
);
    import cst_pkg::*;

    localparam int AW = (MAX_TOKEN_LEN > 1) ? $clog2(MAX_TOKEN_LEN) : 1;
    localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_TOKEN_LEN);

    logic [7:0] tok_mem [MAX_TOKEN_LEN];

    ctl_t             ctl_reg, ctl_next;
    mode_t            mode_reg, mode_next;
    logic [LW-1:0]    len_reg, len_next;
    logic [7:0]       quote_reg, quote_next;
    logic [LINE_W-1:0] line_reg, line_next, line_out_next;
    logic [LINE_W-1:0] line_out_reg;
    logic [LW-1:0]    emit_len_reg;
    logic [LW-1:0]    idx_reg;
    logic             pend_reg, pend_next;
    logic [7:0]       pend_char_reg;
    err_t             err_reg, err_next;

    logic             rd_vld_reg;
    logic             rd_last_reg;
    logic [7:0]       rdata_reg;

    logic             out_valid_reg;
    logic [7:0]       out_char_reg;
    logic             out_last_reg;
    logic [LINE_W-1:0] out_line_reg;
    err_t             out_err_reg;

    logic             accept;
    logic             take_emit, take_label, take_wr;
    logic [AW-1:0]    wr_addr;
    logic             do_append, do_start;
    logic [LW-1:0]    app_len;
    logic             eoi;
    logic [7:0]       b;

    logic             out_free;
    logic             rd_en;
    logic             rd_last;
    logic             load_label, load_err, load_rd;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [7:0]       mem_wdata;

    assign b        = s_tdata;
    assign eoi      = s_tlast;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign app_len  = len_reg + LW'(1);
    assign rd_last  = (idx_reg + LW'(1)) == emit_len_reg;

    // Byte decode
    always_comb
    begin
        mode_next     = mode_reg;
        len_next      = len_reg;
        quote_next    = quote_reg;
        take_emit     = 1'b0;
        take_label    = 1'b0;
        take_wr       = 1'b0;
        wr_addr       = len_reg[AW-1:0];
        pend_next     = 1'b0;
        err_next      = ERR_NONE;
        do_append     = 1'b0;
        do_start      = 1'b0;
        line_next     = line_reg;
        line_out_next = line_reg;
        if (eoi)
        begin
            line_next = LINE_W'(1);
            mode_next = MODE_IDLE;
            len_next  = '0;
            case (mode_reg)
                MODE_IDLE: ;
                MODE_STR, MODE_STR_ESC: err_next = ERR_OPEN_STR;
                MODE_COMMENT, MODE_COMMENT_STAR: err_next = ERR_OPEN_CMT;
                default: take_emit = 1'b1;
            endcase
        end
        else
        begin
            if (b == CH_NL && line_reg < LINE_MAX)
                line_next = line_reg + LINE_W'(1);
            line_out_next = line_next;
            unique case (mode_reg)
                MODE_IDENT:
                begin
                    if (is_ident(b))
                        do_append = 1'b1;
                    else if (b == CH_COLON)
                    begin
                        take_emit  = 1'b1;
                        take_label = 1'b1;
                    end
                    else
                    begin
                        take_emit = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                MODE_HASH:
                begin
                    if (is_ident(b))
                        do_append = 1'b1;
                    else
                    begin
                        take_emit = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                MODE_OPS:
                begin
                    if (is_op(b))
                        do_append = 1'b1;
                    else
                    begin
                        take_emit = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                MODE_STR:
                begin
                    if (b == quote_reg)
                        mode_next = MODE_STR_DONE;
                    else
                    begin
                        do_append = 1'b1;
                        if (b == CH_BSLASH)
                            mode_next = MODE_STR_ESC;
                    end
                end
                MODE_STR_ESC:
                begin
                    do_append = 1'b1;
                    mode_next = MODE_STR;
                end
                MODE_SLASH:
                begin
                    if (b == CH_STAR)
                    begin
                        len_next  = '0;
                        mode_next = MODE_COMMENT;
                    end
                    else if (b == CH_SLASH)
                    begin
                        do_append = 1'b1;
                        mode_next = MODE_DONE;
                    end
                    else
                    begin
                        take_emit = 1'b1;
                        do_start  = 1'b1;
                    end
                end
                MODE_COMMENT:
                begin
                    if (b == CH_STAR)
                        mode_next = MODE_COMMENT_STAR;
                end
                MODE_COMMENT_STAR:
                begin
                    if (b == CH_SLASH)
                        mode_next = MODE_IDLE;
                    else if (b != CH_STAR)
                        mode_next = MODE_COMMENT;
                end
                MODE_STR_DONE, MODE_DONE:
                begin
                    take_emit = 1'b1;
                    do_start  = 1'b1;
                end
                default: do_start = 1'b1;
            endcase
            if (take_emit)
            begin
                mode_next = MODE_IDLE;
                len_next  = '0;
            end
            if (do_append)
            begin
                take_wr  = 1'b1;
                len_next = app_len;
                if (app_len == MAX_LEN)
                    err_next = ERR_TOO_LONG;
            end
            if (do_start && !is_blank(b))
            begin
                mode_next = start_mode(b);
                len_next  = LW'(1);
                if (b == CH_SQUOTE || b == CH_DQUOTE)
                    quote_next = b;
                if (take_emit)
                    pend_next = 1'b1;
                else
                begin
                    take_wr = 1'b1;
                    wr_addr = '0;
                end
            end
        end
    end

    // Next control state
    always_comb
    begin
        ctl_next = ctl_reg;
        unique case (ctl_reg)
            CTL_RUN:
            begin
                if (accept)
                begin
                    if (err_next != ERR_NONE)
                        ctl_next = CTL_ERROR;
                    else if (take_label)
                        ctl_next = CTL_LABEL;
                    else if (take_emit)
                        ctl_next = CTL_EMIT;
                end
            end
            CTL_LABEL:
            begin
                if (out_free)
                    ctl_next = CTL_EMIT;
            end
            CTL_EMIT:
            begin
                if (rd_en && rd_last)
                    ctl_next = CTL_RUN;
            end
            CTL_ERROR:
            begin
                if (out_free && !rd_vld_reg)
                    ctl_next = CTL_HALT;
            end
            CTL_HALT: ;
            default: ctl_next = CTL_RUN;
        endcase
    end

    // Control outputs
    always_comb
    begin
        s_tready   = 1'b0;
        rd_en      = 1'b0;
        load_label = 1'b0;
        load_err   = 1'b0;
        unique case (ctl_reg)
            CTL_RUN:   s_tready = !rd_vld_reg;
            CTL_LABEL: load_label = out_free;
            CTL_EMIT:  rd_en = !rd_vld_reg || out_free;
            CTL_ERROR: load_err = out_free && !rd_vld_reg;
            CTL_HALT:  s_tready = 1'b1;
            default: ;
        endcase
    end

    assign load_rd = rd_vld_reg && out_free;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr;
        mem_wdata = b;
        if (ctl_reg == CTL_RUN && accept && take_wr)
            mem_we = 1'b1;
        else if (rd_en && idx_reg == '0 && pend_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = pend_char_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            tok_mem[mem_waddr] <= mem_wdata;
        if (rd_en)
        begin
            rdata_reg   <= tok_mem[idx_reg[AW-1:0]];
            rd_last_reg <= rd_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= CTL_RUN;
            mode_reg      <= MODE_IDLE;
            len_reg       <= '0;
            quote_reg     <= '0;
            line_reg      <= LINE_W'(1);
            pend_reg      <= 1'b0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
            if (ctl_reg == CTL_RUN && accept)
            begin
                mode_reg  <= mode_next;
                len_reg   <= len_next;
                quote_reg <= quote_next;
                line_reg  <= line_next;
                pend_reg  <= pend_next;
                idx_reg   <= '0;
            end
            else if (rd_en)
            begin
                idx_reg <= idx_reg + LW'(1);
                if (idx_reg == '0)
                    pend_reg <= 1'b0;
            end
            if (rd_en)
                rd_vld_reg <= 1'b1;
            else if (load_rd)
                rd_vld_reg <= 1'b0;
            if (load_rd || load_label || load_err)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl_reg == CTL_RUN && accept)
        begin
            line_out_reg  <= line_out_next;
            emit_len_reg  <= len_reg;
            pend_char_reg <= b;
            err_reg       <= err_next;
        end
        if (load_rd)
        begin
            out_char_reg <= rdata_reg;
            out_last_reg <= rd_last_reg;
            out_line_reg <= line_out_reg;
            out_err_reg  <= ERR_NONE;
        end
        else if (load_label)
        begin
            out_char_reg <= CH_COLON;
            out_last_reg <= (emit_len_reg == '0);
            out_line_reg <= line_out_reg;
            out_err_reg  <= ERR_NONE;
        end
        else if (load_err)
        begin
            out_char_reg <= '0;
            out_last_reg <= 1'b1;
            out_line_reg <= line_out_reg;
            out_err_reg  <= err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_line_reg, out_char_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

endmodule

`default_nettype wire

/* src/cst_checker.sv */
// Port checker for the C source tokenizer and its bind to the top level.
`default_nettype none

module cst_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [1:0]  m_tuser
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result request changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != 2'd0 |-> m_tlast && m_tdata[7:0] == 8'd0)
        else $error("error result is not a single zero character");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser != 2'd0 |=> !m_tvalid)
        else $error("result after error");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31:8] != 24'd0)
        else $error("line number zero");

endmodule

bind c_source_tokenizer cst_checker u_cst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

/* dv/testbench.sv */
// Testbench for c_source_tokenizer: streams C-like source bytes in and checks every token character.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cst_pkg::*;

    localparam int TOK_MAX = 32;
    localparam int QUIET_TAIL = 30;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS = 20;
    localparam string WORD_CHARS =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    localparam string OP_CHARS = "<=>|&!-";

    typedef struct {
        logic [7:0] data;
        logic       eoi;
        bit         drain;
    } src_byte_t;

    typedef struct {
        logic [7:0]        ch;
        logic              last;
        logic [LINE_W-1:0] line;
        err_t              err;
    } tok_char_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [31:0] m_tdata;
    wire         m_tlast;
    wire  [1:0]  m_tuser;

    src_byte_t source_bytes[$];
    tok_char_t pending_chars[$];
    bit        drain_next = 1'b0;

    // lexer model state
    logic [7:0]        lx_buf [TOK_MAX];
    int                lx_len = 0;
    mode_t             lx_mode = MODE_IDLE;
    logic [7:0]        lx_quote = '0;
    logic [LINE_W-1:0] lx_line = LINE_W'(1);
    bit                lx_halted = 1'b0;

    int   n_bytes = 0;
    int   n_results = 0;
    int   n_tokens = 0;
    int   n_fail = 0;
    err_t err_seen = ERR_NONE;

    int tx_cyc = 0;
    int tx_gap = 0;
    int tx_level = 0;
    int rx_cyc = 0;
    int rx_gap = 0;
    int rx_level = 0;

    c_source_tokenizer #(
        .MAX_TOKEN_LEN(TOK_MAX)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic bit word_char(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
               (b >= "0" && b <= "9") || b == "_";
    endfunction

    function automatic bit op_char(input logic [7:0] b);
        return b == "<" || b == "=" || b == ">" || b == "|" ||
               b == "&" || b == "!" || b == "-";
    endfunction

    function automatic void put_char(input logic [7:0] c, input logic l, input err_t e);
        tok_char_t r;
        r.ch = c;
        r.last = l;
        r.line = lx_line;
        r.err = e;
        pending_chars.push_back(r);
    endfunction

    function automatic void raise_error(input err_t e);
        put_char(8'h00, 1'b1, e);
        lx_halted = 1'b1;
    endfunction

    function automatic void flush_token(input bit label);
        int n;
        int i;
        n = (lx_len > TOK_MAX) ? TOK_MAX : lx_len;
        if (label)
            put_char(CH_COLON, n == 0, ERR_NONE);
        for (i = 0; i < n; i++)
            put_char(lx_buf[i], i + 1 == n, ERR_NONE);
        lx_len = 0;
        lx_mode = MODE_IDLE;
    endfunction

    function automatic bit add_char(input logic [7:0] b);
        if (lx_len >= TOK_MAX)
            return 1'b0;
        lx_buf[lx_len] = b;
        lx_len++;
        return lx_len < TOK_MAX;
    endfunction

    function automatic bit begin_token(input logic [7:0] b);
        lx_len = 0;
        if (b == CH_SPACE || b == CH_TAB)
        begin
            lx_mode = MODE_IDLE;
            return 1'b1;
        end
        if (b == CH_HASH)
            lx_mode = MODE_HASH;
        else if (word_char(b))
            lx_mode = MODE_IDENT;
        else if (op_char(b))
            lx_mode = MODE_OPS;
        else if (b == CH_SQUOTE || b == CH_DQUOTE)
        begin
            lx_mode = MODE_STR;
            lx_quote = b;
        end
        else if (b == CH_SLASH)
            lx_mode = MODE_SLASH;
        else
            lx_mode = MODE_DONE;
        return add_char(b);
    endfunction

    function automatic void lex_byte(input logic [7:0] b, input logic eoi);
        bit ok;
        ok = 1'b1;
        if (lx_halted)
            return;
        if (eoi)
        begin
            case (lx_mode)
                MODE_IDLE: ;
                MODE_STR, MODE_STR_ESC:
                begin
                    raise_error(ERR_OPEN_STR);
                    return;
                end
                MODE_COMMENT, MODE_COMMENT_STAR:
                begin
                    raise_error(ERR_OPEN_CMT);
                    return;
                end
                default: flush_token(1'b0);
            endcase
            lx_len = 0;
            lx_mode = MODE_IDLE;
            lx_line = LINE_W'(1);
            return;
        end
        if (b == CH_NL && lx_line != LINE_MAX)
            lx_line++;
        case (lx_mode)
            MODE_IDENT:
            begin
                if (word_char(b))
                    ok = add_char(b);
                else if (b == CH_COLON)
                    flush_token(1'b1);
                else
                begin
                    flush_token(1'b0);
                    ok = begin_token(b);
                end
            end
            MODE_HASH:
            begin
                if (word_char(b))
                    ok = add_char(b);
                else
                begin
                    flush_token(1'b0);
                    ok = begin_token(b);
                end
            end
            MODE_OPS:
            begin
                if (op_char(b))
                    ok = add_char(b);
                else
                begin
                    flush_token(1'b0);
                    ok = begin_token(b);
                end
            end
            MODE_STR:
            begin
                if (b == lx_quote)
                    lx_mode = MODE_STR_DONE;
                else
                begin
                    ok = add_char(b);
                    if (b == CH_BSLASH)
                        lx_mode = MODE_STR_ESC;
                end
            end
            MODE_STR_ESC:
            begin
                ok = add_char(b);
                lx_mode = MODE_STR;
            end
            MODE_SLASH:
            begin
                if (b == CH_STAR)
                begin
                    lx_len = 0;
                    lx_mode = MODE_COMMENT;
                end
                else if (b == CH_SLASH)
                begin
                    ok = add_char(b);
                    lx_mode = MODE_DONE;
                end
                else
                begin
                    flush_token(1'b0);
                    ok = begin_token(b);
                end
            end
            MODE_COMMENT:
            begin
                if (b == CH_STAR)
                    lx_mode = MODE_COMMENT_STAR;
            end
            MODE_COMMENT_STAR:
            begin
                if (b == CH_SLASH)
                    lx_mode = MODE_IDLE;
                else if (b != CH_STAR)
                    lx_mode = MODE_COMMENT;
            end
            MODE_STR_DONE, MODE_DONE:
            begin
                flush_token(1'b0);
                ok = begin_token(b);
            end
            default: ok = begin_token(b);
        endcase
        if (!ok)
            raise_error(ERR_TOO_LONG);
    endfunction

    task automatic add_src(input logic [7:0] b, input logic eoi = 1'b0);
        src_byte_t item;
        item.data = b;
        item.eoi = eoi;
        item.drain = drain_next;
        drain_next = 1'b0;
        source_bytes.push_back(item);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_src(s[i]);
    endtask

    task automatic add_word(input int n);
        int i;
        for (i = 0; i < n; i++)
            add_src(WORD_CHARS[$urandom_range(0, 62)]);
    endtask

    task automatic add_blank();
        case ($urandom_range(0, 2))
            0: add_src(CH_SPACE);
            1: add_src(CH_TAB);
            default: add_src(CH_NL);
        endcase
    endtask

    task automatic add_ops(input int n);
        int i;
        for (i = 0; i < n; i++)
            add_src(OP_CHARS[$urandom_range(0, 6)]);
    endtask

    // sender: hold the request until accepted, insert idle bursts, pause for drain marks
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (tx_cyc % 64 == 0)
                tx_level = $urandom_range(0, 3);
            tx_cyc++;
            if (s_tvalid && s_tready)
            begin
                lex_byte(s_tdata, s_tlast);
                void'(source_bytes.pop_front());
                n_bytes++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (source_bytes.size() == 0 ||
                         (source_bytes[0].drain && pending_chars.size() != 0))
                    s_tvalid <= 1'b0;
                else if (source_bytes.size() > QUIET_TAIL &&
                         $urandom_range(0, 7) < tx_level)
                begin
                    tx_gap = $urandom_range(0, 7);
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= source_bytes[0].data;
                    s_tlast <= source_bytes[0].eoi;
                end
            end
        end
    end

    // receiver: compare each token character with the oldest prediction
    always @(posedge clk)
    begin
        tok_char_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_cyc % 64 == 0)
                rx_level = $urandom_range(0, 3);
            rx_cyc++;
            if (m_tvalid && m_tready)
            begin
                if (pending_chars.size() == 0)
                begin
                    if (n_fail < MAX_REPORTS)
                        $display("%0t: unexpected result char=%h last=%b line=%0d err=%0d",
                                 $time, m_tdata[7:0], m_tlast, m_tdata[31:8], m_tuser);
                    n_fail++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    n_results++;
                    if (m_tlast && m_tuser == ERR_NONE)
                        n_tokens++;
                    if (m_tuser != ERR_NONE)
                        err_seen = m_tuser;
                    if (m_tdata[7:0] !== want.ch || m_tlast !== want.last ||
                        m_tdata[31:8] !== want.line || m_tuser !== want.err)
                    begin
                        if (n_fail < MAX_REPORTS)
                            $display({"%0t: mismatch expected char=%h last=%b line=%0d err=%0d,",
                                      " actual char=%h last=%b line=%0d err=%0d"},
                                     $time, want.ch, want.last, want.line, want.err,
                                     m_tdata[7:0], m_tlast, m_tdata[31:8], m_tuser);
                        n_fail++;
                    end
                end
            end
            if (rx_gap > 0)
            begin
                rx_gap--;
                m_tready <= 1'b0;
            end
            else if (source_bytes.size() > QUIET_TAIL && $urandom_range(0, 7) < rx_level)
            begin
                rx_gap = $urandom_range(0, 7);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int i;
        int n;
        logic [7:0] q;
        logic [7:0] c;

        // label, hash before colon, byte extremes, escaped quote, blanks, ops
        add_text("aZ_9:");
        add_text("#d:");
        add_src(8'h00);
        add_src(8'hFF);
        add_text("'\\''");
        add_src(CH_TAB);
        add_text("<=");
        // comment whose first body char is a slash, line comment, lone slash
        add_text("/*/*/");
        add_text("//");
        add_text("/\n");
        add_src(8'h00, 1'b1);

        // longest label and longest plain word that still fit
        drain_next = 1'b1;
        add_word(TOK_MAX - 1);
        add_src(CH_COLON);
        add_blank();
        add_word(TOK_MAX - 1);
        add_blank();

        while (source_bytes.size() < 120)
        begin
            case ($urandom_range(0, 11))
                0, 1:
                begin
                    add_word($urandom_range(1, 6));
                    add_blank();
                end
                2:
                begin
                    add_word($urandom_range(1, 6));
                    add_src(CH_COLON);
                    add_blank();
                end
                3:
                begin
                    add_src(CH_HASH);
                    add_word($urandom_range(0, 4));
                    add_blank();
                end
                4:
                begin
                    add_ops($urandom_range(1, 3));
                    add_blank();
                end
                5:
                begin
                    q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                    add_src(q);
                    n = $urandom_range(0, 8);
                    for (i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 4) == 0)
                        begin
                            add_src(CH_BSLASH);
                            add_src(8'($urandom_range(0, 255)));
                        end
                        else
                        begin
                            do c = 8'($urandom_range(0, 255));
                            while (c == q || c == CH_BSLASH);
                            add_src(c);
                        end
                    end
                    add_src(q);
                end
                6:
                begin
                    add_text("/*");
                    n = $urandom_range(0, 6);
                    for (i = 0; i < n; i++)
                    begin
                        if (i == 0 && $urandom_range(0, 1))
                            c = CH_SLASH;
                        else
                            do c = 8'($urandom_range(0, 255));
                            while (c == CH_SLASH);
                        add_src(c);
                    end
                    add_text("*/");
                end
                7:
                begin
                    if ($urandom_range(0, 1))
                        add_text("//");
                    else
                        add_src(CH_SLASH);
                    add_blank();
                end
                8:
                begin
                    do c = 8'($urandom_range(0, 255));
                    while (c == CH_SQUOTE || c == CH_DQUOTE || c == CH_SLASH);
                    add_src(c);
                    add_blank();
                end
                9: add_blank();
                10:
                begin
                    if ($urandom_range(0, 1))
                        add_src(8'($urandom_range(0, 255)), 1'b1);
                    else
                        add_src(CH_NL);
                end
                default:
                begin
                    add_word($urandom_range(1, 3));
                    add_ops($urandom_range(1, 3));
                    add_blank();
                end
            endcase
        end

        // finish with one fatal case, then bytes the halted block must drop
        add_src(CH_SPACE);
        drain_next = 1'b1;
        case (err_t'($urandom_range(1, 3)))
            ERR_TOO_LONG: add_word(TOK_MAX);
            ERR_OPEN_STR:
            begin
                add_src(CH_DQUOTE);
                add_word($urandom_range(0, 3));
                if ($urandom_range(0, 1))
                    add_src(CH_BSLASH);
                add_src(8'($urandom_range(0, 255)), 1'b1);
            end
            default:
            begin
                add_text("/*");
                if ($urandom_range(0, 1))
                    add_src(CH_STAR);
                add_src(8'($urandom_range(0, 255)), 1'b1);
            end
        endcase
        for (i = 0; i < 4; i++)
            add_src(8'($urandom_range(0, 255)));
        add_src(8'($urandom_range(0, 255)), 1'b1);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (source_bytes.size() != 0 || pending_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d source bytes, %0d token characters, %0d whole tokens",
                 n_bytes, n_results, n_tokens);
        $display("source ended on error code %0d, %0d mismatches", err_seen, n_fail);
        if (n_fail == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("timeout with %0d bytes unsent and %0d results outstanding",
                 source_bytes.size(), pending_chars.size());
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

/* c_source_tokenizer.f */
src/cst_pkg.sv
src/c_source_tokenizer.sv
src/cst_checker.sv
dv/testbench.sv
